/* design/cmf_pkg.sv */
// cube map face package: face codes and the per-item tag that rides the chain
// no dependencies

package cmf_pkg;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_POS_Y = 3'd1,
    FACE_POS_Z = 3'd2,
    FACE_NEG_X = 3'd3,
    FACE_NEG_Y = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    face_t face;
    logic  zero;
    logic  sat_u;
    logic  sat_v;
  } tag_t;

endpackage

/* design/cmf_select.sv */
// cube map face front cell: major axis pick, minor axes, numerators and divisor
// depends on cmf_pkg

module cmf_select import cmf_pkg::*; #(
  parameter int CB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CB-1:0] dir_x,
  input  logic [CB-1:0] dir_y,
  input  logic [CB-1:0] dir_z,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB:0]   num_u,
  output logic [CB:0]   num_v,
  output logic [CB:0]   den,
  output tag_t          tag
);

  logic signed [CB:0]   sx, sy, sz;
  logic signed [CB:0]   nx, ny, nz;
  logic [CB-1:0]        ax, ay, az;
  logic [CB-1:0]        maj;
  logic signed [CB:0]   mu, mv;
  logic signed [CB+1:0] su, sv;
  logic [CB:0]          nu_w, nv_w, d_w;
  face_t                face_w;
  logic                 zero_w;

  always_comb begin
    sx = {dir_x[CB-1], dir_x};
    sy = {dir_y[CB-1], dir_y};
    sz = {dir_z[CB-1], dir_z};
    nx = -sx;
    ny = -sy;
    nz = -sz;
    ax = sx[CB] ? nx[CB-1:0] : sx[CB-1:0];
    ay = sy[CB] ? ny[CB-1:0] : sy[CB-1:0];
    az = sz[CB] ? nz[CB-1:0] : sz[CB-1:0];
    zero_w = ~|{dir_x, dir_y, dir_z};
    if (ax >= ay && ax >= az) begin
      maj = ax;
      mv  = sy;
      if (!sx[CB] && |dir_x) begin
        face_w = FACE_POS_X;
        mu     = nz;
      end else begin
        face_w = FACE_NEG_X;
        mu     = sz;
      end
    end else if (ay >= az) begin
      maj = ay;
      mu  = sx;
      if (!sy[CB]) begin
        face_w = FACE_POS_Y;
        mv     = nz;
      end else begin
        face_w = FACE_NEG_Y;
        mv     = sz;
      end
    end else begin
      maj = az;
      mv  = sy;
      if (!sz[CB]) begin
        face_w = FACE_POS_Z;
        mu     = sx;
      end else begin
        face_w = FACE_NEG_Z;
        mu     = nx;
      end
    end
    su   = {mu[CB], mu} + {2'b00, maj};
    sv   = {mv[CB], mv} + {2'b00, maj};
    nu_w = su[CB:0];
    nv_w = sv[CB:0];
    d_w  = {maj, 1'b0};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num_u     <= nu_w;
      num_v     <= nv_w;
      den       <= d_w;
      tag.face  <= face_w;
      tag.zero  <= zero_w;
      tag.sat_u <= (nu_w == d_w);
      tag.sat_v <= (nv_w == d_w);
    end
  end

endmodule

/* design/cmf_div_cell.sv */
// cube map face division cell: one restoring quotient bit for u and for v
// depends on cmf_pkg

module cmf_div_cell import cmf_pkg::*; #(
  parameter int CB = 16,
  parameter int UV = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CB:0]   rem_u_in,
  input  logic [CB:0]   rem_v_in,
  input  logic [CB:0]   den_in,
  input  logic [UV-1:0] quo_u_in,
  input  logic [UV-1:0] quo_v_in,
  input  tag_t          tag_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB:0]   rem_u,
  output logic [CB:0]   rem_v,
  output logic [CB:0]   den,
  output logic [UV-1:0] quo_u,
  output logic [UV-1:0] quo_v,
  output tag_t          tag
);

  logic [CB+1:0] tu, tv, du, dv;
  logic          bu, bv;

  always_comb begin
    tu = {rem_u_in, 1'b0};
    tv = {rem_v_in, 1'b0};
    bu = tu >= {1'b0, den_in};
    bv = tv >= {1'b0, den_in};
    du = tu - {1'b0, den_in};
    dv = tv - {1'b0, den_in};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_u <= bu ? du[CB:0] : tu[CB:0];
      rem_v <= bv ? dv[CB:0] : tv[CB:0];
      den   <= den_in;
      quo_u <= {quo_u_in[UV-2:0], bu};
      quo_v <= {quo_v_in[UV-2:0], bv};
      tag   <= tag_in;
    end
  end

endmodule

/* design/cube_map_face_uv_core.sv */
// cube map face selection with face coordinates, top level
// depends on cmf_pkg, cmf_select, cmf_div_cell
//
// input channel: dir_x, dir_y, dir_z with dir_valid / dir_stall; an item is
// taken at a clock edge with dir_valid high and dir_stall low
// output channel: face_index, coord_u, coord_v, zero_vector with
// res_valid / res_stall; an item leaves at an edge with res_valid high and
// res_stall low
// one item per cycle sustained while res_stall stays low; a result passes through
// the select cell, which loads at the edge that takes its item, then a row of
// UV_BITS division cells that each make one quotient bit of u and v, and then
// the output register
// every cell holds its own item, so while the receiver stalls the row keeps
// taking items until all cells are full; dir_stall then rises
// a synchronous rst empties every cell and the output register; no item is
// in flight after reset

module cube_map_face_uv_core import cmf_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int UV_BITS        = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      dir_valid,
  output logic                      dir_stall,
  input  logic [COMPONENT_BITS-1:0] dir_x,
  input  logic [COMPONENT_BITS-1:0] dir_y,
  input  logic [COMPONENT_BITS-1:0] dir_z,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [2:0]                face_index,
  output logic [UV_BITS-1:0]        coord_u,
  output logic [UV_BITS-1:0]        coord_v,
  output logic                      zero_vector
);

  localparam int CB = COMPONENT_BITS;
  localparam int UV = UV_BITS;

  logic          vld [0:UV];
  logic          rdy [0:UV];
  logic [CB:0]   rem_u [0:UV];
  logic [CB:0]   rem_v [0:UV];
  logic [CB:0]   den [0:UV];
  logic [UV-1:0] quo_u [0:UV];
  logic [UV-1:0] quo_v [0:UV];
  tag_t          tag [0:UV];
  logic          sel_ready;
  logic          out_load;

  assign dir_stall = !sel_ready;
  assign quo_u[0]  = '0;
  assign quo_v[0]  = '0;

  cmf_select #(.CB(CB)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dir_valid),
    .in_ready  (sel_ready),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .num_u     (rem_u[0]),
    .num_v     (rem_v[0]),
    .den       (den[0]),
    .tag       (tag[0])
  );

  for (genvar i = 0; i < UV; i++) begin : g_cell
    cmf_div_cell #(.CB(CB), .UV(UV)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .rem_u_in  (rem_u[i]),
      .rem_v_in  (rem_v[i]),
      .den_in    (den[i]),
      .quo_u_in  (quo_u[i]),
      .quo_v_in  (quo_v[i]),
      .tag_in    (tag[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .rem_u     (rem_u[i+1]),
      .rem_v     (rem_v[i+1]),
      .den       (den[i+1]),
      .quo_u     (quo_u[i+1]),
      .quo_v     (quo_v[i+1]),
      .tag       (tag[i+1])
    );
  end

  assign out_load = !res_valid || !res_stall;
  assign rdy[UV]  = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= vld[UV];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[UV]) begin
      face_index  <= tag[UV].face;
      zero_vector <= tag[UV].zero;
      if (tag[UV].zero) begin
        coord_u <= '0;
        coord_v <= '0;
      end else begin
        coord_u <= tag[UV].sat_u ? '1 : quo_u[UV];
        coord_v <= tag[UV].sat_v ? '1 : quo_v[UV];
      end
    end
  end

`ifndef SYNTH
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_vector |->
      face_index == FACE_NEG_X && coord_u == '0 && coord_v == '0)
    else $error("zero vector result not cleared");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> face_index <= FACE_NEG_Z)
    else $error("face index out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    dir_stall |-> vld[0] && res_valid)
    else $error("input stalled while the row has room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[UV] && out_load |=> res_valid)
    else $error("finished item lost at the output register");
`endif

endmodule

/* tb/sv/tb_cube_map_face_uv_core.sv */
// testbench for cube_map_face_uv_core: face selection and u,v coordinates
// checked against an in-bench predictor, with random idling and backpressure
// depends on cmf_pkg and cube_map_face_uv_core
`timescale 1ns / 1ps

module tb_cube_map_face_uv_core;
  import cmf_pkg::*;

  localparam int COMPONENT_BITS = 16;
  localparam int UV_BITS        = 16;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int CYCLE_LIMIT    = 400000;
  localparam longint UV_MAX     = (longint'(1) << UV_BITS) - 1;

  typedef struct {
    face_t              face;
    logic [UV_BITS-1:0] u;
    logic [UV_BITS-1:0] v;
    logic               zero;
  } face_uv_t;

  logic                      clk;
  logic                      rst;
  logic                      dir_valid;
  logic                      dir_stall;
  logic [COMPONENT_BITS-1:0] dir_x;
  logic [COMPONENT_BITS-1:0] dir_y;
  logic [COMPONENT_BITS-1:0] dir_z;
  logic                      res_valid;
  logic                      res_stall;
  logic [2:0]                face_index;
  logic [UV_BITS-1:0]        coord_u;
  logic [UV_BITS-1:0]        coord_v;
  logic                      zero_vector;

  face_uv_t expected_uv_q[$];
  int       error_count;
  int       dirs_sent;
  int       results_checked;
  int       cycle_count;
  int       rx_wait;
  int       hold_cycles;
  bit       tx_idle_en;
  bit       rx_idle_en;

  cube_map_face_uv_core #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .UV_BITS(UV_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .dir_valid(dir_valid),
    .dir_stall(dir_stall),
    .dir_x(dir_x),
    .dir_y(dir_y),
    .dir_z(dir_z),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .face_index(face_index),
    .coord_u(coord_u),
    .coord_v(coord_v),
    .zero_vector(zero_vector)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [UV_BITS-1:0] uv_coord(input longint minor, input longint major_mag);
    longint q;
    q = ((minor + major_mag) << UV_BITS) / (2 * major_mag);
    if (q > UV_MAX) q = UV_MAX;
    return q[UV_BITS-1:0];
  endfunction

  function automatic face_uv_t predict_face_uv(input logic [COMPONENT_BITS-1:0] x,
                                               input logic [COMPONENT_BITS-1:0] y,
                                               input logic [COMPONENT_BITS-1:0] z);
    face_uv_t r;
    longint   c[3];
    longint   best;
    longint   m;
    longint   mu;
    longint   mv;
    int       axis;
    c[0] = $signed(x);
    c[1] = $signed(y);
    c[2] = $signed(z);
    best = 0;
    axis = 0;
    mu   = 0;
    mv   = 0;
    for (int i = 0; i < 3; i++) begin
      m = (c[i] < 0) ? -c[i] : c[i];
      if (m > best) begin
        best = m;
        axis = i;
      end
    end
    r.zero = 1'b0;
    case (axis)
      0: r.face = (c[0] > 0) ? FACE_POS_X : FACE_NEG_X;
      1: r.face = (c[1] > 0) ? FACE_POS_Y : FACE_NEG_Y;
      default: r.face = (c[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
    endcase
    if (best == 0) begin
      r.face = FACE_NEG_X;
      r.u    = '0;
      r.v    = '0;
      r.zero = 1'b1;
      return r;
    end
    case (r.face)
      FACE_POS_X: begin mu = -c[2]; mv = c[1];  end
      FACE_POS_Y: begin mu = c[0];  mv = -c[2]; end
      FACE_POS_Z: begin mu = c[0];  mv = c[1];  end
      FACE_NEG_X: begin mu = c[2];  mv = c[1];  end
      FACE_NEG_Y: begin mu = c[0];  mv = c[2];  end
      default:    begin mu = -c[0]; mv = c[1];  end
    endcase
    r.u = uv_coord(mu, best);
    r.v = uv_coord(mv, best);
    return r;
  endfunction

  // caller is at a falling edge; returns at a falling edge
  task automatic send_dir(input int x, input int y, input int z);
    int       gap;
    face_uv_t item_exp;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      dir_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    dir_valid <= 1'b1;
    dir_x     <= x[COMPONENT_BITS-1:0];
    dir_y     <= y[COMPONENT_BITS-1:0];
    dir_z     <= z[COMPONENT_BITS-1:0];
    do @(posedge clk); while (dir_stall);
    item_exp = predict_face_uv(x[COMPONENT_BITS-1:0], y[COMPONENT_BITS-1:0],
                               z[COMPONENT_BITS-1:0]);
    expected_uv_q = {expected_uv_q, item_exp};
    dirs_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    face_uv_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_uv_q.size() == 0) begin
        error_count++;
        $error("result with no item pending: face_index %0d coord_u %0d coord_v %0d",
               face_index, coord_u, coord_v);
      end else begin
        want = expected_uv_q.pop_front();
        results_checked++;
        if (face_index !== want.face) begin
          error_count++;
          $error("face_index mismatch: expected %0d, actual %0d", want.face, face_index);
        end
        if (coord_u !== want.u) begin
          error_count++;
          $error("coord_u mismatch: expected %0d, actual %0d", want.u, coord_u);
        end
        if (coord_v !== want.v) begin
          error_count++;
          $error("coord_v mismatch: expected %0d, actual %0d", want.v, coord_v);
        end
        if (zero_vector !== want.zero) begin
          error_count++;
          $error("zero_vector mismatch: expected %0d, actual %0d", want.zero, zero_vector);
        end
      end
      rx_wait = rx_idle_en ? $urandom_range(0, 4) : 0;
    end
  end

  // receiver side: long hold-off first, then per-item stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles--;
    end else if (rx_wait > 0) begin
      res_stall <= 1'b1;
      rx_wait--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic int rand_signed(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic int rand_sign(input int a);
    return $urandom_range(0, 1) ? -a : a;
  endfunction

  task automatic test_faces();
    send_dir(100, 10, -20);
    send_dir(10, 100, 20);
    send_dir(10, -20, 100);
    send_dir(-100, 30, -40);
    send_dir(50, -100, 99);
    send_dir(-99, 0, -100);
    send_dir(1, 0, 0);
    send_dir(-1, 0, 0);
    send_dir(0, 0, -1);
    send_dir(0, 0, 32767);
  endtask

  task automatic test_extremes();
    send_dir(-32768, 32767, -32767);
    send_dir(32767, 32767, 32767);
    send_dir(-32768, -32768, -32768);
    send_dir(0, -32768, 0);
    send_dir(32767, -32768, 32767);
  endtask

  task automatic test_ties_and_saturation();
    send_dir(0, 5, -5);
    send_dir(0, -5, 5);
    send_dir(7, -7, 0);
    send_dir(-7, 7, 0);
    send_dir(100, 100, -100);
    send_dir(-3, 3, 3);
  endtask

  task automatic test_zero_vector();
    send_dir(0, 0, 0);
    send_dir(0, 0, 0);
  endtask

  task automatic make_random_dir(output int x, output int y, output int z);
    int a;
    case ($urandom_range(0, 9))
      3: begin
        x = rand_signed(-8, 8);
        y = rand_signed(-8, 8);
        z = rand_signed(-8, 8);
      end
      4: begin
        a = $urandom_range(1, 32767);
        x = $urandom_range(0, 1) ? rand_sign(a) : rand_signed(-a, a);
        y = rand_sign(a);
        z = $urandom_range(0, 1) ? rand_sign(a) : rand_signed(-a, a);
      end
      5: begin
        a = $urandom_range(1, 32767);
        x = rand_sign(a);
        y = rand_sign(a);
        z = rand_sign(a);
      end
      6: begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
        z = $urandom_range(0, 65535);
        case ($urandom_range(0, 2))
          0: x = $urandom_range(0, 1) ? -32768 : rand_sign(32767);
          1: y = $urandom_range(0, 1) ? -32768 : rand_sign(32767);
          default: z = $urandom_range(0, 1) ? -32768 : rand_sign(32767);
        endcase
      end
      7: begin
        x = 0;
        y = 0;
        z = 0;
        case ($urandom_range(0, 3))
          0: x = $urandom_range(0, 65535);
          1: y = $urandom_range(0, 65535);
          2: z = $urandom_range(0, 65535);
          default: ;
        endcase
      end
      default: begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
        z = $urandom_range(0, 65535);
      end
    endcase
  endtask

  task automatic test_random(input int count);
    int x;
    int y;
    int z;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        case ((i / 200) % 4)
          0: begin tx_idle_en = 1'b0; rx_idle_en = 1'b0; end
          1: begin tx_idle_en = 1'b1; rx_idle_en = 1'b0; end
          2: begin tx_idle_en = 1'b0; rx_idle_en = 1'b1; end
          default: begin tx_idle_en = 1'b1; rx_idle_en = 1'b1; end
        endcase
      end
      make_random_dir(x, y, z);
      send_dir(x, y, z);
    end
  endtask

  task automatic test_backpressure();
    int x;
    int y;
    int z;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    hold_cycles = 150;
    for (int i = 0; i < 50; i++) begin
      make_random_dir(x, y, z);
      send_dir(x, y, z);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst             = 1'b1;
    dir_valid       = 1'b0;
    dir_x           = '0;
    dir_y           = '0;
    dir_z           = '0;
    res_stall       = 1'b0;
    error_count     = 0;
    dirs_sent       = 0;
    results_checked = 0;
    cycle_count     = 0;
    rx_wait         = 0;
    hold_cycles     = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_faces();
    test_extremes();
    test_ties_and_saturation();
    test_zero_vector();
    test_backpressure();
    test_random(RANDOM_ITEMS);

    dir_valid <= 1'b0;
    wait (expected_uv_q.size() == 0);
    repeat (UV_BITS + 8) @(posedge clk);

    $display("%0d directions sent (all faces, ties, extremes, zero vector, long stall),",
             dirs_sent);
    $display("%0d results compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cmf_pkg.sv
design/cmf_select.sv
design/cmf_div_cell.sv
design/cube_map_face_uv_core.sv
tb/sv/tb_cube_map_face_uv_core.sv
